// ===== hdl/rwz_pkg.sv =====
// ----------------------------------------------------------------------------
// rwz_pkg: shared types and constants of the rolling window z-score block
// Beat formats, fixed field widths and controller states.
// ----------------------------------------------------------------------------
package rwz_pkg;

	localparam int SAMPLE_BITS  = 24;
	localparam int ZS_W         = 20;
	localparam int ZS_FRAC      = 16;
	localparam int CFG_W        = 7;
	localparam int WINDOW_RESET = 20;

	localparam logic [ZS_W-1:0] ZS_MAX     = 20'h7FFFF;
	localparam logic [ZS_W-1:0] ZS_MIN_MAG = 20'h80000;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          sample_missing;
	} sample_t;

	typedef struct packed {
		logic signed [ZS_W-1:0] zscore;
		logic                   zscore_valid;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SQUARE,
		ST_UPDATE,
		ST_MULT,
		ST_PREP,
		ST_SQRT,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// ===== hdl/rwz_sqrt.sv =====
// ----------------------------------------------------------------------------
// rwz_sqrt: digit-serial floored integer square root
// Takes two radicand bits per cycle and settles one root bit per cycle.
// ----------------------------------------------------------------------------
module rwz_sqrt #(
	parameter int R_W = 30
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [2*R_W-1:0] x,
	output logic             done,
	output logic [R_W-1:0]   root
);

	localparam int C_W = $clog2(R_W + 1);

	logic [2*R_W-1:0] x_q;
	logic [R_W+1:0]   rem_q;
	logic [R_W-1:0]   root_q;
	logic [C_W-1:0]   cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [R_W+1:0] rem_sh;
	logic [R_W+1:0] trial;
	logic           take;

	always_comb begin
		rem_sh = {rem_q[R_W-1:0], x_q[2*R_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		take   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == C_W'(R_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + C_W'(1);
				if (cnt_q == C_W'(R_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[2*R_W-3:0], 2'b00};
			rem_q  <= take ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[R_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== hdl/rwz_div.sv =====
// ----------------------------------------------------------------------------
// rwz_div: bit-serial restoring divider
// Produces one quotient bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module rwz_div #(
	parameter int N   = 48,
	parameter int D_W = 30
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N-1:0]   dividend,
	input  logic [D_W-1:0] divisor,
	output logic           done,
	output logic [N-1:0]   quotient
);

	localparam int C_W = $clog2(N + 1);

	logic [N-1:0]   num_q;
	logic [D_W-1:0] rem_q;
	logic [D_W-1:0] den_q;
	logic [C_W-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;

	logic [D_W:0] rem_sh;
	logic [D_W:0] diff;
	logic         take;

	always_comb begin
		rem_sh = {rem_q, num_q[N-1]};
		take   = (rem_sh >= {1'b0, den_q});
		diff   = rem_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == C_W'(N - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + C_W'(1);
				if (cnt_q == C_W'(N - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// The quotient bits shift in behind the dividend bits as they are used.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[N-2:0], take};
			rem_q <= take ? diff[D_W-1:0] : rem_sh[D_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = num_q;

endmodule

// ===== hdl/rolling_window_zscore_core.sv =====
// ----------------------------------------------------------------------------
// rolling_window_zscore_core: z-score of each sample over a rolling window
// Ring of recent samples, running sums, bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Usage:
// The sample channel (sample_valid, sample_stall, sample_data) takes one beat
// per item; the result channel (result_valid, result_stall, result_data)
// returns exactly one beat per item, in order. The cfg channel (cfg_valid,
// cfg_ready, cfg_data) writes the window length, clamped to 1..MAX_WINDOW,
// and restarts the window; write it only while no item is in flight.
// One item is worked at a time. The bit-serial squaring step (the new sample
// and the leaving sample, squared side by side), the three bit-serial
// multipliers (working together), the root unit and the divider run one after
// another; the root and divider are skipped when the result is invalid.
// The next sample is taken as soon as the result has moved to the output
// register, even if the receiver still stalls it; a stalled result holds and
// delays only the completion of the following item.
// Reset sets the window length to 20 (or MAX_WINDOW if smaller) and empties
// the window; the ring memory needs no clearing pass.
// ----------------------------------------------------------------------------
module rolling_window_zscore_core #(
	parameter int MAX_WINDOW = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  rwz_pkg::sample_t              sample_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output rwz_pkg::result_t              result_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rwz_pkg::CFG_W-1:0]     cfg_data
);

	localparam int SB      = rwz_pkg::SAMPLE_BITS;
	localparam int PTR_W   = $clog2(MAX_WINDOW);
	localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W   = SB + CNT_W;
	localparam int SQ_W    = CNT_W + 2 * SB - 2;
	localparam int MAG_W   = SUM_W - 1;
	localparam int A_W     = CNT_W + SQ_W;
	localparam int R_W     = (A_W + 1) / 2;
	localparam int X_W     = 2 * R_W;
	localparam int P_W     = SUM_W + 1;
	localparam int DIV_N   = P_W + rwz_pkg::ZS_FRAC;
	localparam int MUL_N   = MAG_W;
	localparam int PH_W    = $clog2(MUL_N + 1);
	localparam int CMP_W   = (CNT_W > rwz_pkg::CFG_W) ? CNT_W : rwz_pkg::CFG_W;
	localparam int LEN_RST = (MAX_WINDOW < rwz_pkg::WINDOW_RESET) ?
		MAX_WINDOW : rwz_pkg::WINDOW_RESET;

	rwz_pkg::state_t state_q, state_nxt;

	logic [CNT_W-1:0]        len_q;
	logic [PTR_W-1:0]        pos_q;
	logic [CNT_W-1:0]        seen_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SQ_W-1:0]         sq_q;

	logic [SB:0]             ring [MAX_WINDOW];
	logic [SB:0]             rd_q;
	logic signed [SB-1:0]    v_q;
	logic                    miss_q;

	logic [PH_W-1:0]         ph_q;
	logic [SB-1:0]           vbits_q, obits_q;
	logic [2*SB-1:0]         vsq_q, osq_q;
	logic [MUL_N-1:0]        mc_q, ms_q;
	logic [A_W-1:0]          a_q, b_q;
	logic signed [P_W-1:0]   p_q;
	logic                    ok_q;
	logic                    neg_q;
	logic [P_W-1:0]          nmag_q;
	rwz_pkg::result_t        res_q;
	rwz_pkg::result_t        out_q;
	logic                    ovalid_q;

	logic                    sample_acc, cfg_acc, out_load;
	logic                    sqrt_start, sqrt_done, div_start, div_done;
	logic [R_W-1:0]          root;
	logic [DIV_N-1:0]        quot;

	logic signed [SB-1:0]    old_v;
	logic [SB-1:0]           vm_c, om_c;
	logic                    full, old_p;
	logic signed [SUM_W-1:0] sum_n;
	logic [SQ_W-1:0]         sq_n;
	logic [CNT_W-1:0]        cnt_n, seen_n, pos_inc;
	logic [PTR_W-1:0]        pos_n;
	logic                    ok_n;
	logic [MAG_W-1:0]        smag_c, smag_n;
	logic [A_W-1:0]          d_c;
	logic signed [P_W-1:0]   num_c;
	logic [P_W-1:0]          nmag_c;
	logic [CMP_W-1:0]        cfg_ext;
	logic [CNT_W-1:0]        len_new;
	logic [rwz_pkg::ZS_W-1:0] zmag, zval;

	function automatic logic [MAG_W-1:0] sum_mag(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-1:0] m;
		m = x[SUM_W-1] ? (~x + 1'b1) : x;
		return m[MAG_W-1:0];
	endfunction

	assign sample_acc = sample_valid && !sample_stall;
	assign cfg_acc    = cfg_valid && cfg_ready;
	assign cfg_ready  = (state_q == rwz_pkg::ST_IDLE);
	assign sample_stall = (state_q != rwz_pkg::ST_IDLE) || cfg_valid;
	assign out_load   = (state_q == rwz_pkg::ST_DONE) && (!ovalid_q || !result_stall);

	// Window bookkeeping for the item being worked, the clamped window length and the saturated z-score.
	always_comb begin
		old_v   = rd_q[SB-1:0];
		vm_c    = v_q[SB-1] ? (~v_q + 1'b1) : v_q;
		om_c    = old_v[SB-1] ? (~old_v + 1'b1) : old_v;
		full    = (seen_q >= len_q);
		old_p   = full && rd_q[SB];
		sum_n   = sum_q - (old_p ? SUM_W'(old_v) : '0) + (miss_q ? '0 : SUM_W'(v_q));
		sq_n    = sq_q - (old_p ? SQ_W'(osq_q) : '0) + (miss_q ? '0 : SQ_W'(vsq_q));
		cnt_n   = cnt_q - CNT_W'(old_p) + CNT_W'(!miss_q);
		seen_n  = full ? seen_q : seen_q + CNT_W'(1);
		ok_n    = (seen_n >= len_q) && (cnt_n >= CNT_W'(2)) && !miss_q;
		pos_inc = CNT_W'(pos_q) + CNT_W'(1);
		pos_n   = (pos_inc == len_q) ? '0 : pos_inc[PTR_W-1:0];
		smag_c  = sum_mag(sum_q);
		smag_n  = sum_mag(sum_n);
		d_c     = a_q - b_q;
		num_c   = p_q - P_W'(sum_q);
		nmag_c  = num_c[P_W-1] ? (~num_c + 1'b1) : num_c;
		cfg_ext = CMP_W'(cfg_data);
		if (cfg_ext == '0) begin
			len_new = CNT_W'(1);
		end else if (cfg_ext > CMP_W'(MAX_WINDOW)) begin
			len_new = CNT_W'(MAX_WINDOW);
		end else begin
			len_new = cfg_ext[CNT_W-1:0];
		end
		if (neg_q) begin
			zmag = (quot > DIV_N'(rwz_pkg::ZS_MIN_MAG)) ? rwz_pkg::ZS_MIN_MAG :
				quot[rwz_pkg::ZS_W-1:0];
			zval = ~zmag + 1'b1;
		end else begin
			zmag = (quot > DIV_N'(rwz_pkg::ZS_MAX)) ? rwz_pkg::ZS_MAX :
				quot[rwz_pkg::ZS_W-1:0];
			zval = zmag;
		end
	end

	// Next state and unit strobes.
	always_comb begin
		state_nxt  = state_q;
		sqrt_start = 1'b0;
		div_start  = 1'b0;
		case (state_q)
			rwz_pkg::ST_IDLE: begin
				if (sample_acc) state_nxt = rwz_pkg::ST_LOAD;
			end
			rwz_pkg::ST_LOAD: begin
				state_nxt = rwz_pkg::ST_SQUARE;
			end
			rwz_pkg::ST_SQUARE: begin
				if (ph_q == PH_W'(SB - 1)) state_nxt = rwz_pkg::ST_UPDATE;
			end
			rwz_pkg::ST_UPDATE: begin
				state_nxt = rwz_pkg::ST_MULT;
			end
			rwz_pkg::ST_MULT: begin
				if (ph_q == PH_W'(MUL_N - 1)) state_nxt = rwz_pkg::ST_PREP;
			end
			rwz_pkg::ST_PREP: begin
				if (ok_q && (a_q > b_q)) begin
					sqrt_start = 1'b1;
					state_nxt  = rwz_pkg::ST_SQRT;
				end else begin
					state_nxt = rwz_pkg::ST_DONE;
				end
			end
			rwz_pkg::ST_SQRT: begin
				if (sqrt_done) begin
					if (root != '0) begin
						div_start = 1'b1;
						state_nxt = rwz_pkg::ST_DIV;
					end else begin
						state_nxt = rwz_pkg::ST_DONE;
					end
				end
			end
			rwz_pkg::ST_DIV: begin
				if (div_done) state_nxt = rwz_pkg::ST_DONE;
			end
			rwz_pkg::ST_DONE: begin
				if (out_load) state_nxt = rwz_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = rwz_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rwz_pkg::ST_IDLE;
			len_q    <= CNT_W'(LEN_RST);
			pos_q    <= '0;
			seen_q   <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			sq_q     <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_acc) begin
				len_q  <= len_new;
				pos_q  <= '0;
				seen_q <= '0;
				cnt_q  <= '0;
				sum_q  <= '0;
				sq_q   <= '0;
			end else if (state_q == rwz_pkg::ST_UPDATE) begin
				pos_q  <= pos_n;
				seen_q <= seen_n;
				cnt_q  <= cnt_n;
				sum_q  <= sum_n;
				sq_q   <= sq_n;
			end
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (!result_stall) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// Ring memory: read the slot to be overwritten when the sample arrives.
	always_ff @(posedge clk) begin
		if (sample_acc) begin
			rd_q <= ring[pos_q];
		end
		if (state_q == rwz_pkg::ST_UPDATE) begin
			ring[pos_q] <= {!miss_q, miss_q ? {SB{1'b0}} : v_q};
		end
	end

	// Bit-serial datapath; every product is formed most significant bit first.
	always_ff @(posedge clk) begin
		case (state_q)
			rwz_pkg::ST_IDLE: begin
				if (sample_acc) begin
					v_q    <= sample_data.sample;
					miss_q <= sample_data.sample_missing;
				end
			end
			rwz_pkg::ST_LOAD: begin
				ph_q    <= '0;
				vbits_q <= vm_c;
				obits_q <= om_c;
				vsq_q   <= '0;
				osq_q   <= '0;
			end
			rwz_pkg::ST_SQUARE: begin
				ph_q    <= ph_q + PH_W'(1);
				vbits_q <= {vbits_q[SB-2:0], 1'b0};
				obits_q <= {obits_q[SB-2:0], 1'b0};
				vsq_q   <= {vsq_q[2*SB-2:0], 1'b0} + (vbits_q[SB-1] ? (2*SB)'(vm_c) : '0);
				osq_q   <= {osq_q[2*SB-2:0], 1'b0} + (obits_q[SB-1] ? (2*SB)'(om_c) : '0);
			end
			rwz_pkg::ST_UPDATE: begin
				ph_q <= '0;
				ok_q <= ok_n;
				mc_q <= MUL_N'(cnt_n);
				ms_q <= smag_n;
				a_q  <= '0;
				b_q  <= '0;
				p_q  <= '0;
			end
			rwz_pkg::ST_MULT: begin
				ph_q <= ph_q + PH_W'(1);
				mc_q <= {mc_q[MUL_N-2:0], 1'b0};
				ms_q <= {ms_q[MUL_N-2:0], 1'b0};
				a_q  <= {a_q[A_W-2:0], 1'b0} + (mc_q[MUL_N-1] ? A_W'(sq_q) : '0);
				b_q  <= {b_q[A_W-2:0], 1'b0} + (ms_q[MUL_N-1] ? A_W'(smag_c) : '0);
				p_q  <= (p_q <<< 1) + (mc_q[MUL_N-1] ? P_W'(v_q) : '0);
			end
			rwz_pkg::ST_PREP: begin
				neg_q  <= num_c[P_W-1];
				nmag_q <= nmag_c;
				res_q  <= '0;
			end
			rwz_pkg::ST_DIV: begin
				if (div_done) begin
					res_q.zscore       <= zval;
					res_q.zscore_valid <= 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q <= res_q;
		end
	end

	rwz_sqrt #(
		.R_W(R_W)
	) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (X_W'(d_c)),
		.done   (sqrt_done),
		.root   (root)
	);

	rwz_div #(
		.N   (DIV_N),
		.D_W (R_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({nmag_q, {rwz_pkg::ZS_FRAC{1'b0}}}),
		.divisor  (root),
		.done     (div_done),
		.quotient (quot)
	);

	assign result_valid = ovalid_q;
	assign result_data  = out_q;

	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= len_q)
		else $error("items seen exceeds window length");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= seen_q)
		else $error("present count exceeds items seen");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(pos_q) < len_q)
		else $error("write position outside the window");

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		sample_acc |=> (state_q == rwz_pkg::ST_LOAD))
		else $error("accepted sample did not start processing");

endmodule
